[src/pbr_pkg.sv]
package pbr_pkg;

   localparam int MAX_DIM    = 512;
   localparam int STORE_ROWS = 512;
   localparam int STORE_COLS = 64;

   localparam int ROW_W    = $clog2(STORE_ROWS);
   localparam int COL_W    = $clog2(STORE_COLS);
   localparam int ADDR_W   = ROW_W + COL_W;
   localparam int PIX_W    = COL_W + 3;
   localparam int DIM_W    = 10;
   localparam int STRIDE_W = 7;
   localparam int ROT_W    = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   localparam logic [7:0] TOP_BIT = 8'h80;

   localparam logic [CSR_IDX_W-1:0] REG_ROTATION   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_WIDTH  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_HEIGHT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_IN_STRIDE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_STRIDE = 3'd4;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_READ  = 1'b1;

   typedef struct packed {
      logic             mode;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] byte_col;
      logic [7:0]       in_data;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       range_error;
   } rsp_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        wdata;
   } mem_cmd_type;

   // one tag per store read, issued with the read address; registered, it lines up with the read data
   typedef struct packed {
      logic       live;
      logic       take;
      logic [2:0] bit_sel;
   } rd_tag_type;

endpackage

[src/pbr_store.sv]
module pbr_store (
   input  logic                clock,
   input  pbr_pkg::mem_cmd_type cmd,
   output logic [7:0]          rdata
);
   import pbr_pkg::*;

   logic [7:0] mem [STORE_ROWS*STORE_COLS];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         mem[cmd.addr] <= cmd.wdata;
      end
      rdata_ff <= mem[cmd.addr];
   end

   assign rdata = rdata_ff;

endmodule

[src/pbr_gather.sv]
module pbr_gather (
   input  logic                clock,
   input  logic                reset,
   input  pbr_pkg::rd_tag_type tag,
   input  logic [7:0]          rdata,
   output logic [7:0]          gathered
);
   import pbr_pkg::*;

   rd_tag_type tag_ff;
   logic [7:0] byte_ff;
   logic       pix;

   // pixel picked out of the byte just read; masked when the source is off the image or past the input stride
   assign pix = tag_ff.take && (|(rdata & (TOP_BIT >> tag_ff.bit_sel)));

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag;
      end
   end

   // eight shifts replace the whole byte, leftmost pixel first
   always_ff @(posedge clock) begin
      if (tag_ff.live) begin
         byte_ff <= {byte_ff[6:0], pix};
      end
   end

   assign gathered = byte_ff;

endmodule

[src/pbr_seq.sv]
module pbr_seq (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   input  logic [pbr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pbr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  pbr_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output pbr_pkg::rsp_type                  rsp_data,
   output pbr_pkg::mem_cmd_type              mem_cmd,
   output pbr_pkg::rd_tag_type               tag,
   input  logic [7:0]                        gathered
);
   import pbr_pkg::*;

   typedef enum logic [1:0] {IDLE, FETCH, DRAIN, DONE} state_type;

   state_type           state_ff;
   logic [2:0]          idx_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [COL_W-1:0]    col_ff;
   logic                mode_ff;
   logic                err_ff;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   logic [ROT_W-1:0]    rotation_ff;
   logic [DIM_W-1:0]    out_width_ff;
   logic [DIM_W-1:0]    out_height_ff;
   logic [STRIDE_W-1:0] in_stride_ff;
   logic [STRIDE_W-1:0] out_stride_ff;

   logic [DIM_W-1:0]    w;
   logic [DIM_W-1:0]    h;
   logic [DIM_W-1:0]    in_h;
   logic                accept;
   logic                err_in;
   logic [PIX_W-1:0]    x;
   logic                x_in_image;
   logic [DIM_W-1:0]    hm1y;
   logic [DIM_W-1:0]    wm1x;
   logic [ROW_W-1:0]    src_r;
   logic [PIX_W-1:0]    src_c;
   logic                rsp_free;

   assign w    = (out_width_ff  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : out_width_ff;
   assign h    = (out_height_ff > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : out_height_ff;
   assign in_h = rotation_ff[0] ? w : h;

   assign req_stall = (state_ff != IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (req_data.mode == MODE_WRITE) begin
         err_in = ({1'b0, req_data.row} >= in_h) ||
                  ({1'b0, req_data.byte_col} >= in_stride_ff);
      end else begin
         err_in = ({1'b0, req_data.row} >= h) ||
                  ({1'b0, req_data.byte_col} >= out_stride_ff);
      end
   end

   // position of output pixel idx_ff of the current byte
   assign x          = {col_ff, idx_ff};
   assign x_in_image = ({1'b0, x} < w);
   assign hm1y       = h - DIM_W'(1) - {1'b0, row_ff};
   assign wm1x       = w - DIM_W'(1) - {1'b0, x};

   always_comb begin
      case (rotation_ff)
         2'd0: begin
            src_r = row_ff;
            src_c = x;
         end
         2'd1: begin
            src_r = x;
            src_c = hm1y[PIX_W-1:0];
         end
         2'd2: begin
            src_r = hm1y[ROW_W-1:0];
            src_c = wm1x[PIX_W-1:0];
         end
         default: begin
            src_r = wm1x[ROW_W-1:0];
            src_c = row_ff;
         end
      endcase
   end

   always_comb begin
      tag.live    = (state_ff == FETCH);
      tag.take    = x_in_image && ({1'b0, src_c[PIX_W-1:3]} < in_stride_ff);
      tag.bit_sel = src_c[2:0];
   end

   always_comb begin
      mem_cmd.wdata = req_data.in_data;
      if (state_ff == IDLE) begin
         mem_cmd.we   = accept && (req_data.mode == MODE_WRITE) && !err_in;
         mem_cmd.addr = {req_data.row, req_data.byte_col};
      end else begin
         mem_cmd.we   = 1'b0;
         mem_cmd.addr = {src_r, src_c[PIX_W-1:3]};
      end
   end

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         rotation_ff   <= '0;
         out_width_ff  <= DIM_W'(512);
         out_height_ff <= DIM_W'(512);
         in_stride_ff  <= STRIDE_W'(64);
         out_stride_ff <= STRIDE_W'(64);
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_ROTATION:   rotation_ff   <= csr_wdata[ROT_W-1:0];
               REG_OUT_WIDTH:  out_width_ff  <= csr_wdata[DIM_W-1:0];
               REG_OUT_HEIGHT: out_height_ff <= csr_wdata[DIM_W-1:0];
               REG_IN_STRIDE:  in_stride_ff  <= csr_wdata[STRIDE_W-1:0];
               REG_OUT_STRIDE: out_stride_ff <= csr_wdata[STRIDE_W-1:0];
               default: ;
            endcase
         end

         if ((state_ff == DONE) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            IDLE: begin
               if (accept) begin
                  row_ff  <= req_data.row;
                  col_ff  <= req_data.byte_col;
                  mode_ff <= req_data.mode;
                  err_ff  <= err_in;
                  idx_ff  <= '0;
                  if ((req_data.mode == MODE_READ) && !err_in) begin
                     state_ff <= FETCH;
                  end else begin
                     state_ff <= DONE;
                  end
               end
            end
            FETCH: begin
               idx_ff <= idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  state_ff <= DRAIN;
               end
            end
            DRAIN: begin
               state_ff <= DONE;
            end
            DONE: begin
               if (rsp_free) begin
                  rsp_ff.range_error   <= err_ff;
                  rsp_ff.out_byte      <= ((mode_ff == MODE_READ) && !err_ff) ? gathered : 8'h00;
                  state_ff             <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[src/packed_bitmap_rotate90.sv]
// One-bit packed image rotator (0, 90, 180, 270 degrees anticlockwise). Write items
// load input bytes into a 512 x 64 byte image store; read items return one byte
// of the rotated image. A write goes from IDLE straight to DONE. A read goes
// through FETCH, where the single store port delivers one source byte per cycle
// and the eight pixels of an output byte are fetched one after another, then
// DRAIN, where the last pixel is shifted in, then DONE, where the result is
// registered. The next item can be taken once the result is offered; no item
// is taken while the previous one is in flight. A result left waiting on rsp_stall
// holds the following item in its last cycle, and the input stalls meanwhile.
// The store is not cleared at reset and reads of bytes never written are
// undefined. Configuration writes are always taken and must only be made while
// idle.
module packed_bitmap_rotate90 (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pbr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pbr_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  pbr_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output pbr_pkg::rsp_type               rsp_data
);
   import pbr_pkg::*;

   mem_cmd_type mem_cmd;
   rd_tag_type  tag;
   logic [7:0]  rdata;
   logic [7:0]  gathered;

   assign csr_ready = 1'b1;

   pbr_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .mem_cmd   (mem_cmd),
      .tag       (tag),
      .gathered  (gathered)
   );

   pbr_store u_store (
      .clock (clock),
      .cmd   (mem_cmd),
      .rdata (rdata)
   );

   pbr_gather u_gather (
      .clock    (clock),
      .reset    (reset),
      .tag      (tag),
      .rdata    (rdata),
      .gathered (gathered)
   );

   // store is only written in the cycle a write item is taken
   a_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      mem_cmd.we |-> (req_valid && !req_stall && (req_data.mode == MODE_WRITE)))
      else $error("store written outside an accepted write item");

   // one item at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while previous one still in flight");

   // flagged results never carry pixel data
   a_error_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.range_error) |-> (rsp_data.out_byte == 8'h00))
      else $error("range error with nonzero output byte");

   // no store read issued while idle
   a_fetch_only_busy: assert property (@(posedge clock) disable iff (reset)
      tag.live |-> req_stall)
      else $error("pixel fetch while idle");

endmodule

[tb/pbr_checker.sv]
package pbr_tb_pkg;
   import pbr_pkg::*;

   typedef enum logic [ROT_W-1:0] {
      ROT_0   = 2'd0,
      ROT_90  = 2'd1,
      ROT_180 = 2'd2,
      ROT_270 = 2'd3
   } rotation_e;

   // no register sits at this index, writes to it are dropped
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v);
      return (v > MAX_DIM) ? MAX_DIM : int'(v);
   endfunction

   // Where output pixel (x, y) comes from. Returns 0 when the pixel is
   // padding or its source byte lies outside the input stride or the store.
   function automatic bit locate_source(rotation_e rot, int unsigned w, int unsigned h,
                                        int unsigned in_stride, int unsigned y,
                                        int unsigned x, output int unsigned r,
                                        output int unsigned bc,
                                        output int unsigned bit_sel);
      int unsigned c;
      r = 0;
      bc = 0;
      bit_sel = 0;
      if (x >= w)
         return 1'b0;
      case (rot)
         ROT_0: begin
            r = y;
            c = x;
         end
         ROT_90: begin
            r = x;
            c = h - 1 - y;
         end
         ROT_180: begin
            r = h - 1 - y;
            c = w - 1 - x;
         end
         default: begin
            r = w - 1 - x;
            c = y;
         end
      endcase
      bc = c >> 3;
      bit_sel = 7 - (c & 7);
      return r < STORE_ROWS && bc < STORE_COLS && bc < in_stride;
   endfunction

endpackage

module pbr_checker
   import pbr_pkg::*;
   import pbr_tb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   output int unsigned           mismatches,
   output int unsigned           pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned MAX_REPORTS = 200;

   logic [7:0]          image [STORE_ROWS][STORE_COLS];
   rotation_e           rot_q;
   logic [DIM_W-1:0]    width_q;
   logic [DIM_W-1:0]    height_q;
   logic [STRIDE_W-1:0] in_stride_q;
   logic [STRIDE_W-1:0] out_stride_q;
   rsp_type             rotated_q [$];
   int unsigned         errors;

   // updates the image copy on writes, works out the rotated byte on reads
   function automatic rsp_type apply_item(req_type item);
      int unsigned w, h, in_rows, r, bc, bit_sel;
      rsp_type res;
      res = '0;
      w = clamp_dim(width_q);
      h = clamp_dim(height_q);
      in_rows = (rot_q == ROT_90 || rot_q == ROT_270) ? w : h;
      if (item.mode == MODE_WRITE) begin
         if (item.row >= in_rows || item.byte_col >= in_stride_q)
            res.range_error = 1'b1;
         else
            image[item.row][item.byte_col] = item.in_data;
      end else if (item.row >= h || item.byte_col >= out_stride_q) begin
         res.range_error = 1'b1;
      end else begin
         for (int i = 0; i < 8; i++)
            if (locate_source(rot_q, w, h, in_stride_q, item.row,
                              int'(item.byte_col) * 8 + i, r, bc, bit_sel))
               res.out_byte[7-i] = image[r][bc][bit_sel];
      end
      return res;
   endfunction

   function automatic void report(string what, logic [7:0] want, logic [7:0] got);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("%0t: %s expected %02h, got %02h", $time, what, want, got);
      else if (errors == MAX_REPORTS + 1)
         $display("%0t: further mismatches not shown", $time);
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rot_q = ROT_0;
         width_q = DIM_W'(MAX_DIM);
         height_q = DIM_W'(MAX_DIM);
         in_stride_q = STRIDE_W'(STORE_COLS);
         out_stride_q = STRIDE_W'(STORE_COLS);
         rotated_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_ROTATION:   rot_q = rotation_e'(csr_wdata[ROT_W-1:0]);
               REG_OUT_WIDTH:  width_q = csr_wdata[DIM_W-1:0];
               REG_OUT_HEIGHT: height_q = csr_wdata[DIM_W-1:0];
               REG_IN_STRIDE:  in_stride_q = csr_wdata[STRIDE_W-1:0];
               REG_OUT_STRIDE: out_stride_q = csr_wdata[STRIDE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            rotated_q.push_back(apply_item(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (rotated_q.size() == 0) begin
               report("item with nothing outstanding: out_byte", 8'h00, rsp_data.out_byte);
            end else begin
               want = rotated_q.pop_front();
               if (rsp_data.out_byte !== want.out_byte)
                  report("out_byte", want.out_byte, rsp_data.out_byte);
               if (rsp_data.range_error !== want.range_error)
                  report("range_error", 8'(want.range_error), 8'(rsp_data.range_error));
            end
         end
      end
      mismatches <= errors;
      pending <= rotated_q.size();
   end

endmodule

[tb/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pbr_pkg::*;
   import pbr_tb_pkg::*;

   localparam int unsigned PHASES          = 16;
   localparam int unsigned ITEMS_PER_PHASE = 112;
   localparam int unsigned IDLE_PCT        = 38;
   localparam int unsigned HOLD_OFF_CYCLES = 400;
   localparam int unsigned WATCHDOG_LIMIT  = 4000;
   localparam int unsigned TAIL_CYCLES     = 30;

   typedef struct {
      rotation_e   rot;
      int unsigned w;
      int unsigned h;
      int unsigned in_s;
      int unsigned out_s;
   } setting_t;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   int unsigned           mismatches;
   int unsigned           pending;

   bit          written [STORE_ROWS][STORE_COLS];
   rotation_e   cur_rot;
   int unsigned cur_w, cur_h, cur_is, cur_os;
   bit          idle_en;
   bit          hold_off_pending;
   int unsigned n_writes, n_reads, n_settings, sent;
   int unsigned stuck_cycles;

   always #10 clock = ~clock;

   packed_bitmap_rotate90 dut (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   pbr_checker pixel_check (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // output side back-pressure, with one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= idle_en && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("status: fail");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   function automatic req_type make_item(logic mode, int unsigned row, int unsigned col,
                                         logic [7:0] data);
      req_type item;
      item.mode = mode;
      item.row = row[ROW_W-1:0];
      item.byte_col = col[COL_W-1:0];
      item.in_data = data;
      return item;
   endfunction

   function automatic int unsigned input_rows();
      return (cur_rot == ROT_90 || cur_rot == ROT_270) ? cur_w : cur_h;
   endfunction

   // mostly random, now and then one of the two ends
   function automatic int unsigned pick_index(int unsigned n);
      case ($urandom_range(0, 7))
         0: return 0;
         1: return n - 1;
         default: return $urandom_range(0, n - 1);
      endcase
   endfunction

   function automatic bit sources_written(int unsigned y, int unsigned b);
      int unsigned r, bc, bit_sel;
      for (int i = 0; i < 8; i++)
         if (locate_source(cur_rot, cur_w, cur_h, cur_is, y, b * 8 + i, r, bc, bit_sel) &&
             !written[r][bc])
            return 1'b0;
      return 1'b1;
   endfunction

   task automatic send(req_type item);
      if (idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < IDLE_PCT);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      if (item.mode == MODE_WRITE)
         n_writes++;
      else
         n_reads++;
      sent++;
   endtask

   // caller guarantees the position lies inside the input image
   task automatic put_write(int unsigned row, int unsigned col, logic [7:0] data);
      send(make_item(MODE_WRITE, row, col, data));
      written[row][col] = 1'b1;
   endtask

   task automatic put_read(int unsigned y, int unsigned b);
      send(make_item(MODE_READ, y, b, 8'($urandom)));
   endtask

   // loads the source bytes an output byte needs, then reads it
   task automatic read_back(int unsigned y, int unsigned b);
      int unsigned r, bc, bit_sel;
      for (int i = 0; i < 8; i++)
         if (locate_source(cur_rot, cur_w, cur_h, cur_is, y, b * 8 + i, r, bc, bit_sel) &&
             (!written[r][bc] || $urandom_range(0, 3) == 0))
            put_write(r, bc, 8'($urandom));
      put_read(y, b);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic csr_put(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(setting_t s, bit poke_unused);
      drain();
      csr_put(REG_ROTATION, CSR_DATA_W'(s.rot));
      csr_put(REG_OUT_WIDTH, CSR_DATA_W'(s.w));
      csr_put(REG_OUT_HEIGHT, CSR_DATA_W'(s.h));
      csr_put(REG_IN_STRIDE, CSR_DATA_W'(s.in_s));
      csr_put(REG_OUT_STRIDE, CSR_DATA_W'(s.out_s));
      if (poke_unused)
         csr_put(REG_UNUSED, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      cur_rot = s.rot;
      cur_w = clamp_dim(DIM_W'(s.w));
      cur_h = clamp_dim(DIM_W'(s.h));
      cur_is = s.in_s;
      cur_os = s.out_s;
      n_settings++;
   endtask

   task automatic random_step();
      int unsigned pick, y, b, rows, cols, n_b;
      req_type noise;
      pick = $urandom_range(0, 99);
      rows = input_rows();
      cols = (cur_is < STORE_COLS) ? cur_is : STORE_COLS;
      n_b = (cur_os < STORE_COLS) ? cur_os : STORE_COLS;
      if (pick < 55 && cur_h > 0 && n_b > 0) begin
         read_back(pick_index(cur_h), pick_index(n_b));
      end else if (pick < 75 && rows > 0 && cols > 0) begin
         put_write(pick_index(rows), pick_index(cols), 8'($urandom));
      end else if (pick < 85) begin
         y = $urandom_range(0, STORE_ROWS - 1);
         b = $urandom_range(0, STORE_COLS - 1);
         if (y >= cur_h || b >= cur_os || sources_written(y, b))
            put_read(y, b);
         else
            read_back(y, b);
      end else begin
         // any position, stored only if it happens to land inside the image
         noise = req_type'($urandom);
         noise.mode = MODE_WRITE;
         send(noise);
      end
   endtask

   initial begin
      setting_t    plan [PHASES];
      int unsigned start;
      bit          paused;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_data = '0;
      idle_en = 1'b1;
      cur_rot = ROT_0;
      cur_w = MAX_DIM;
      cur_h = MAX_DIM;
      cur_is = STORE_COLS;
      cur_os = STORE_COLS;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // settings out of reset: full 512 x 512, unrotated
      put_write(0, 0, 8'hff);
      put_write(STORE_ROWS - 1, STORE_COLS - 1, 8'h81);
      put_read(0, 0);
      put_read(STORE_ROWS - 1, STORE_COLS - 1);

      configure('{ROT_90, 12, 10, 2, 2}, 1'b0);
      send(make_item(MODE_WRITE, 12, 0, 8'h3c));
      send(make_item(MODE_WRITE, 0, 2, 8'h3c));
      put_read(10, 0);
      put_read(0, 2);
      read_back(0, 1);   // lower half of the byte is past the width

      // oversized sizes clamp to 512
      configure('{ROT_180, 1023, 1023, 127, 127}, 1'b0);
      read_back(STORE_ROWS - 1, STORE_COLS - 1);
      read_back(0, 0);

      // source byte beyond the one-byte input stride reads as zero
      configure('{ROT_270, 512, 16, 1, 64}, 1'b0);
      put_read(8, 5);
      send(make_item(MODE_WRITE, 0, 1, 8'h55));

      configure('{ROT_0, 0, 0, 0, 0}, 1'b0);
      put_read(0, 0);
      send(make_item(MODE_WRITE, 0, 0, 8'haa));
      configure('{ROT_0, 0, 5, 1, 1}, 1'b0);
      put_read(4, 0);

      plan[0] = '{ROT_0, 40, 24, 5, 6};
      plan[1] = '{ROT_90, 33, 17, 3, 5};
      plan[2] = '{ROT_180, 17, 40, 3, 3};
      plan[3] = '{ROT_270, 24, 31, 4, 4};
      plan[4] = '{ROT_90, 512, 512, 64, 64};
      plan[5] = '{ROT_270, 1, 1, 1, 1};
      plan[6] = '{ROT_180, 1023, 1023, 127, 127};
      plan[7] = '{ROT_0, 0, 0, 0, 0};
      plan[8] = '{ROT_270, 512, 9, 2, 64};
      plan[9] = '{ROT_90, 9, 300, 1, 2};
      for (int k = 10; k < PHASES; k++)
         plan[k] = '{rotation_e'($urandom_range(0, 3)), $urandom_range(1, 72),
                     $urandom_range(1, 72), $urandom_range(0, 12), $urandom_range(0, 12)};

      for (int ph = 0; ph < PHASES; ph++) begin
         configure(plan[ph], ph == 3);
         idle_en = (ph != 4);
         if (ph == 2)
            hold_off_pending = 1'b1;
         start = sent;
         paused = 1'b0;
         while (sent - start < ITEMS_PER_PHASE) begin
            if (ph == 6 && !paused && sent - start >= ITEMS_PER_PHASE / 2) begin
               drain();
               paused = 1'b1;
            end
            random_step();
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("covered %0d settings: all four rotations, empty, single-pixel, clamped",
               n_settings);
      $display("%0d store writes and %0d byte reads, with an output hold-off and an input pause",
               n_writes, n_reads);
      if (mismatches == 0 && pending == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
